// ----- rtl/scanline_sine_wave_offset_defines.svh -----
// assertion macros used by the checker file
`ifndef SCANLINE_SINE_WAVE_OFFSET_DEFINES_SVH
`define SCANLINE_SINE_WAVE_OFFSET_DEFINES_SVH

// property checked on every clock edge outside reset
`define SWO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SWO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/swo_pkg.sv -----
package swo_pkg;

  // geometry of the wave
  localparam int LINES           = 192;
  localparam int PHASE_PER_ENTRY = 100;
  localparam int PHASE_MOD       = LINES * PHASE_PER_ENTRY;
  localparam int PHASE_W         = $clog2(PHASE_MOD);

  // payload widths
  localparam int LINE_W = 8;
  localparam int WORD_W = 32;
  localparam int STEP_W = 16;
  localparam int AMP_W  = 32;
  localparam int SPD_W  = 16;
  localparam int HALF_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_LINE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SPEED = 3'd4;

  localparam logic [LINE_W-1:0] LAST_LINE_RST = 8'd191;

  // input mode codes
  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // phase / entry by reciprocal multiply: error stays below one entry
  localparam int DIV_SH  = PHASE_W + $clog2(PHASE_PER_ENTRY);
  localparam int DIV_MUL = (1 << DIV_SH) / PHASE_PER_ENTRY + 1;

  // sine table, one quarter turn in Q12
  localparam int QUARTER  = 1024;
  localparam int SINE_W   = 13;
  localparam int SADDR_W  = $clog2(QUARTER + 1);

  // shared multiplier operand widths
  localparam int MUL_A_W = AMP_W + 1;
  localparam int MUL_B_W = ((PHASE_W + 1) > (SINE_W + 1)) ? (PHASE_W + 1) : (SINE_W + 1);
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // running sums
  localparam int ISUM_W = LINE_W + 1;
  localparam int PSUM_W = ((PHASE_W > SPD_W) ? PHASE_W : SPD_W) + 2;

  // rounding of the amplitude product
  localparam int RND_W   = 40;
  localparam int OFS_LSB = 24;

  typedef logic [SINE_W-1:0] sine_rom_t [0:QUARTER];

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    real       pi;
    real       v;
    pi = 3.14159265358979323846;
    for (int k = 0; k <= QUARTER; k++) begin
      v = 4096.0 * $sin(2.0 * pi * real'(k) / 4096.0) + 0.5;
      rom[k] = SINE_W'($rtoi(v));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_QUARTER = build_sine();

endpackage

// ----- rtl/swo_in_if.sv -----
interface swo_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [swo_pkg::LINE_W-1:0]     line_index;
  logic [swo_pkg::WORD_W-1:0]     line_word;

  modport source (output valid, mode, line_index, line_word, input ready);
  modport sink   (input valid, mode, line_index, line_word, output ready);
endinterface

interface swo_out_if;
  logic                           valid;
  logic                           ready;
  logic [swo_pkg::WORD_W-1:0]     result_word;
  logic                           offset_applied;

  modport source (output valid, result_word, offset_applied, input ready);
  modport sink   (input valid, result_word, offset_applied, output ready);
endinterface

interface swo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swo_pkg::CFG_IDX_W-1:0]  index;
  logic [swo_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/scanline_sine_wave_offset.sv -----
// Sine-wave horizontal scroll for per-scanline scroll words.
// Channels: in_i takes beats of {mode, line_index, line_word}; out_o returns
// {result_word, offset_applied}; cfg_i writes registers (0 first_line,
// 1 last_line, 2 angle_step, 3 amplitude, 4 phase_speed), always ready.
// A frame tick (mode 1) moves the phase and gives no result; it holds the
// input while the wrap state adds or subtracts the period until the phase fits.
// A line beat gives exactly one result. Outside first..last the word passes
// unchanged, straight through S_DONE to the output register. Inside, the work
// runs on one shared 33x16 multiplier (phase/100 by reciprocal, index*step,
// sine*amplitude) plus one sine ROM read, stepping DIV, IDX, IWRAP, ANGLE,
// SINE, AMP and DONE; a new line is taken only once it is back in idle.
// in_i.ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next beat is taken while it waits.
// When out_o.ready is low the result holds; a next result then waits in
// S_DONE, and the sequencer takes no more work until it is loaded.
// Reset clears the phase to 0, the registers to their defaults (last_line
// 191, others 0) and drops out_o.valid; nothing else needs clearing.
module scanline_sine_wave_offset (
  input  logic            clk_i,
  input  logic            rst_ni,
  swo_cfg_if.sink         cfg_i,
  swo_in_if.sink          in_i,
  swo_out_if.source       out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PWRAP,
    S_DIV,
    S_IDX,
    S_IWRAP,
    S_ANGLE,
    S_SINE,
    S_AMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // configuration and phase
  logic        [swo_pkg::LINE_W-1:0]  first_q;
  logic        [swo_pkg::LINE_W-1:0]  last_q;
  logic        [swo_pkg::STEP_W-1:0]  step_q;
  logic signed [swo_pkg::AMP_W-1:0]   amp_q;
  logic signed [swo_pkg::SPD_W-1:0]   speed_q;
  logic        [swo_pkg::PHASE_W-1:0] phase_q;

  // datapath
  logic signed [swo_pkg::PSUM_W-1:0]  psum_q;
  logic        [swo_pkg::LINE_W-1:0]  diff_q;
  logic        [swo_pkg::WORD_W-1:0]  word_q;
  logic                               applied_q;
  logic        [swo_pkg::ISUM_W-1:0]  isum_q;
  logic signed [swo_pkg::PROD_W-1:0]  prod_q;
  logic        [swo_pkg::SINE_W-1:0]  mag_q;
  logic                               neg_q;
  logic        [swo_pkg::WORD_W-1:0]  res_word_q;
  logic                               res_applied_q;

  logic                               in_beat;
  logic                               out_load;
  logic                               in_range;
  logic                               psum_done;
  logic signed [swo_pkg::MUL_A_W-1:0] mul_a;
  logic signed [swo_pkg::MUL_B_W-1:0] mul_b;
  logic signed [swo_pkg::PROD_W-1:0]  mul_p;
  logic signed [swo_pkg::SINE_W:0]    sine_s;
  logic        [11:0]                 sidx;
  logic        [swo_pkg::SADDR_W-1:0] saddr;
  logic        [swo_pkg::RND_W-1:0]   rnd;
  logic        [swo_pkg::HALF_W-1:0]  wave_ofs;

  assign cfg_i.ready        = 1'b1;
  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.result_word  = res_word_q;
  assign out_o.offset_applied = res_applied_q;

  assign in_beat  = in_i.valid && in_i.ready;
  assign in_range = (in_i.line_index >= first_q) && (in_i.line_index <= last_q);
  assign psum_done = !psum_q[swo_pkg::PSUM_W-1] &&
                     (psum_q < swo_pkg::PSUM_W'(swo_pkg::PHASE_MOD));

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (in_i.mode == swo_pkg::MODE_TICK) begin
            state_d = S_PWRAP;
          end else if (in_range) begin
            state_d = S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PWRAP: begin
        if (psum_done) begin
          state_d = S_IDLE;
        end
      end
      S_DIV:   state_d = S_IDX;
      S_IDX:   state_d = S_IWRAP;
      S_IWRAP: begin
        if (isum_q < swo_pkg::ISUM_W'(swo_pkg::LINES)) begin
          state_d = S_ANGLE;
        end
      end
      S_ANGLE: state_d = S_SINE;
      S_SINE:  state_d = S_AMP;
      S_AMP:   state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration writes and phase accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= swo_pkg::LAST_LINE_RST;
      step_q  <= '0;
      amp_q   <= '0;
      speed_q <= '0;
      phase_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          swo_pkg::CFG_FIRST_LINE:  first_q <= cfg_i.data[swo_pkg::LINE_W-1:0];
          swo_pkg::CFG_LAST_LINE:   last_q  <= cfg_i.data[swo_pkg::LINE_W-1:0];
          swo_pkg::CFG_ANGLE_STEP:  step_q  <= cfg_i.data[swo_pkg::STEP_W-1:0];
          swo_pkg::CFG_AMPLITUDE:   amp_q   <= cfg_i.data[swo_pkg::AMP_W-1:0];
          swo_pkg::CFG_PHASE_SPEED: speed_q <= cfg_i.data[swo_pkg::SPD_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_PWRAP && psum_done) begin
        phase_q <= psum_q[swo_pkg::PHASE_W-1:0];
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    sine_s = $signed({1'b0, mag_q});
    if (neg_q) begin
      sine_s = -$signed({1'b0, mag_q});
    end
    case (state_q)
      S_DIV: begin
        mul_a = swo_pkg::MUL_A_W'(swo_pkg::DIV_MUL);
        mul_b = swo_pkg::MUL_B_W'(phase_q);
      end
      S_ANGLE: begin
        mul_a = swo_pkg::MUL_A_W'(step_q);
        mul_b = swo_pkg::MUL_B_W'(isum_q);
      end
      S_AMP: begin
        mul_a = swo_pkg::MUL_A_W'(amp_q);
        mul_b = swo_pkg::MUL_B_W'(sine_s);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // quarter-wave fold of the angle
  assign sidx  = prod_q[15:4];
  assign saddr = sidx[10] ? (swo_pkg::SADDR_W'(swo_pkg::QUARTER) - {1'b0, sidx[9:0]})
                          : {1'b0, sidx[9:0]};

  // amplitude product (Q24) with 0x800 added, offset is its integer part from bit 24
  assign rnd      = prod_q[swo_pkg::RND_W-1:0] + swo_pkg::RND_W'(12'h800);
  assign wave_ofs = rnd[swo_pkg::OFS_LSB +: swo_pkg::HALF_W];

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      psum_q    <= $signed(swo_pkg::PSUM_W'(phase_q)) + swo_pkg::PSUM_W'(speed_q);
      diff_q    <= in_i.line_index - first_q;
      word_q    <= in_i.line_word;
      applied_q <= in_range;
    end
    case (state_q)
      S_PWRAP: begin
        if (psum_q[swo_pkg::PSUM_W-1]) begin
          psum_q <= psum_q + swo_pkg::PSUM_W'(swo_pkg::PHASE_MOD);
        end else if (!psum_done) begin
          psum_q <= psum_q - swo_pkg::PSUM_W'(swo_pkg::PHASE_MOD);
        end
      end
      S_DIV, S_ANGLE, S_AMP: prod_q <= mul_p;
      S_IDX: begin
        isum_q <= prod_q[swo_pkg::DIV_SH +: swo_pkg::ISUM_W] + swo_pkg::ISUM_W'(diff_q);
      end
      S_IWRAP: begin
        if (isum_q >= swo_pkg::ISUM_W'(swo_pkg::LINES)) begin
          isum_q <= isum_q - swo_pkg::ISUM_W'(swo_pkg::LINES);
        end
      end
      S_SINE: begin
        mag_q <= swo_pkg::SINE_QUARTER[saddr];
        neg_q <= sidx[11];
      end
      default: ;
    endcase
    if (out_load) begin
      res_applied_q <= applied_q;
      if (applied_q) begin
        res_word_q <= {word_q[swo_pkg::WORD_W-1:swo_pkg::HALF_W],
                       word_q[swo_pkg::HALF_W-1:0] + wave_ofs};
      end else begin
        res_word_q <= word_q;
      end
    end
  end

endmodule

// ----- rtl/swo_checker.sv -----
`include "scanline_sine_wave_offset_defines.svh"

module swo_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_mode_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cfg_ready_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // one item at a time: busy right after a beat
  `SWO_ASSERT(a_busy_after_beat, in_beat |=> !in_ready_i, "input ready right after a beat")

  // no result appears in the cycle after any accepted beat
  `SWO_ASSERT(a_no_instant_result, in_beat |=> !$rose(out_valid_i), "result one cycle after beat")

  // a frame tick never produces a result
  `SWO_ASSERT(a_tick_silent, in_beat && in_mode_i && !out_valid_i |=> !out_valid_i ##1 !out_valid_i,
              "result after frame tick")

  // stalled result holds
  `SWO_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped under stall")

  // nothing valid during reset, config always taken
  `SWO_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_i && cfg_ready_i,
                     "output valid or config stalled in reset")

endmodule

bind scanline_sine_wave_offset swo_checker u_swo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cfg_ready_i (cfg_i.ready)
);

// ----- tb/sv/tb_scanline_sine_wave_offset.sv -----
module tb_scanline_sine_wave_offset;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int SETTLE_CYCLES = 16;
  localparam int GAP_MAX = 8;
  localparam int BURST_MAX = 12;
  localparam int MASK_HOLD = 200;

  // one expected result beat
  typedef struct packed {
    logic [swo_pkg::WORD_W-1:0] word;
    logic                       applied;
  } scroll_t;

  logic clk;
  logic rst_n;

  swo_cfg_if cfg_bus ();
  swo_in_if  line_bus ();
  swo_out_if res_bus ();

  scanline_sine_wave_offset dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (line_bus),
    .out_o  (res_bus)
  );

  // predictor copy of the registers and phase
  logic [swo_pkg::LINE_W-1:0]       first_q;
  logic [swo_pkg::LINE_W-1:0]       last_q;
  logic [swo_pkg::STEP_W-1:0]       step_q;
  logic signed [swo_pkg::AMP_W-1:0] amp_q;
  logic signed [swo_pkg::SPD_W-1:0] speed_q;
  int unsigned                      phase_q;

  int sine_tab [0:swo_pkg::QUARTER];
  scroll_t scroll_q [$];

  int unsigned errors;
  int unsigned lines_sent;
  int unsigned lines_in_range;
  int unsigned ticks_sent;
  int unsigned items_sent;
  int unsigned setups;
  bit          gaps_on;
  int          burst_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // expected scroll word for one line beat
  function automatic scroll_t predict_scroll(logic [swo_pkg::LINE_W-1:0] line,
                                             logic [swo_pkg::WORD_W-1:0] word);
    scroll_t                    r;
    int unsigned                idx;
    logic [15:0]                angle;
    logic [11:0]                tab_idx;
    int                         s;
    logic signed [63:0]         s64;
    logic signed [63:0]         a64;
    logic signed [63:0]         prod;
    logic [swo_pkg::HALF_W-1:0] ofs;
    r.word = word;
    r.applied = 1'b0;
    if (line >= first_q && line <= last_q) begin
      idx = (phase_q / swo_pkg::PHASE_PER_ENTRY + (int'(line) - int'(first_q)))
            % swo_pkg::LINES;
      angle = 16'(idx * step_q);
      tab_idx = angle[15:4];
      // odd quadrants run the quarter table backwards
      if (tab_idx[10])
        s = sine_tab[swo_pkg::QUARTER - int'(tab_idx[9:0])];
      else
        s = sine_tab[tab_idx[9:0]];
      if (tab_idx[11])
        s = -s;
      s64 = s;
      a64 = amp_q;
      prod = s64 * a64 + 64'sd2048;
      ofs = prod[swo_pkg::OFS_LSB +: swo_pkg::HALF_W];
      r.word = {word[swo_pkg::WORD_W-1:swo_pkg::HALF_W],
                word[swo_pkg::HALF_W-1:0] + ofs};
      r.applied = 1'b1;
    end
    return r;
  endfunction

  // one register write beat
  task automatic cfg_write(logic [swo_pkg::CFG_IDX_W-1:0] idx,
                           logic [swo_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      swo_pkg::CFG_FIRST_LINE:  first_q = data[swo_pkg::LINE_W-1:0];
      swo_pkg::CFG_LAST_LINE:   last_q  = data[swo_pkg::LINE_W-1:0];
      swo_pkg::CFG_ANGLE_STEP:  step_q  = data[swo_pkg::STEP_W-1:0];
      swo_pkg::CFG_AMPLITUDE:   amp_q   = data[swo_pkg::AMP_W-1:0];
      swo_pkg::CFG_PHASE_SPEED: speed_q = data[swo_pkg::SPD_W-1:0];
      default: ;
    endcase
  endtask

  // drain all results and let a pending tick finish
  task automatic wait_idle();
    line_bus.valid <= 1'b0;
    while (scroll_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(int first, int last, int step, logic [31:0] amp, int speed);
    logic [swo_pkg::CFG_DATA_W-1:0] junk;
    wait_idle();
    // unused upper data bits must be ignored
    junk = ($urandom_range(1) == 0) ? '0 : swo_pkg::CFG_DATA_W'($urandom);
    cfg_write(swo_pkg::CFG_FIRST_LINE,  {junk[31:8], 8'(first)});
    cfg_write(swo_pkg::CFG_LAST_LINE,   {junk[31:8], 8'(last)});
    cfg_write(swo_pkg::CFG_ANGLE_STEP,  {junk[31:16], 16'(step)});
    cfg_write(swo_pkg::CFG_AMPLITUDE,   amp);
    cfg_write(swo_pkg::CFG_PHASE_SPEED, {junk[31:16], 16'(speed)});
    cfg_bus.valid <= 1'b0;
    setups++;
  endtask

  // one input beat, with burst pacing on the sender side
  task automatic send_item(logic mode, logic [swo_pkg::LINE_W-1:0] line,
                           logic [swo_pkg::WORD_W-1:0] word);
    scroll_t r;
    int      p;
    line_bus.valid      <= 1'b1;
    line_bus.mode       <= mode;
    line_bus.line_index <= line;
    line_bus.line_word  <= word;
    do @(posedge clk); while (!line_bus.ready);
    if (mode == swo_pkg::MODE_TICK) begin
      // true modulo keeps the phase inside one wave period
      p = (int'(phase_q) + int'(speed_q)) % swo_pkg::PHASE_MOD;
      if (p < 0)
        p += swo_pkg::PHASE_MOD;
      phase_q = p;
      ticks_sent++;
    end else begin
      r = predict_scroll(line, word);
      scroll_q.push_back(r);
      lines_sent++;
      if (r.applied)
        lines_in_range++;
    end
    items_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        line_bus.valid <= 1'b0;
        repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        burst_left = $urandom_range(1, BURST_MAX);
      end
    end
  endtask

  // receiver stalls on a rotating mask that changes now and then
  logic [15:0] ready_mask;
  int unsigned mask_age = 0;

  always @(posedge clk) begin
    if (mask_age == 0) begin
      ready_mask = ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
      mask_age = MASK_HOLD;
    end
    mask_age--;
    res_bus.ready <= ready_mask[0];
    ready_mask = {ready_mask[0], ready_mask[15:1]};
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    scroll_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (scroll_q.size() == 0) begin
        $error("unexpected result beat: result_word %h offset_applied %b",
               res_bus.result_word, res_bus.offset_applied);
        errors++;
      end else begin
        want = scroll_q.pop_front();
        if (res_bus.result_word !== want.word) begin
          $error("result_word mismatch: expected %h got %h", want.word,
                 res_bus.result_word);
          errors++;
        end
        if (res_bus.offset_applied !== want.applied) begin
          $error("offset_applied mismatch: expected %b got %b", want.applied,
                 res_bus.offset_applied);
          errors++;
        end
      end
    end
  end

  // defaults after reset: zero amplitude, full range
  task automatic test_reset_defaults();
    send_item(swo_pkg::MODE_LINE, 8'd0, 32'h1234_5678);
    send_item(swo_pkg::MODE_LINE, 8'd191, 32'hFFFF_FFFF);
    send_item(swo_pkg::MODE_LINE, 8'd192, 32'h0000_0000);
    send_item(swo_pkg::MODE_LINE, 8'd255, 32'hA5A5_A5A5);
    send_item(swo_pkg::MODE_TICK, 8'd0, 32'h0);
  endtask

  // quarter-turn steps hit sine zero, peak and trough; peak and trough at both amplitude extremes
  task automatic test_wave_extremes();
    program_regs(0, 191, 16384, 32'h7FFF_FFFF, 0);
    send_item(swo_pkg::MODE_LINE, 8'd0, 32'h0000_FFFF);
    send_item(swo_pkg::MODE_LINE, 8'd1, 32'hFFFF_0000);
    send_item(swo_pkg::MODE_LINE, 8'd2, 32'hFFFF_FFFF);
    send_item(swo_pkg::MODE_LINE, 8'd3, 32'h0000_0000);
    program_regs(0, 191, 16384, 32'h8000_0000, 0);
    send_item(swo_pkg::MODE_LINE, 8'd1, 32'h8000_7FFF);
    send_item(swo_pkg::MODE_LINE, 8'd3, 32'h7FFF_8000);
    program_regs(0, 191, 16'hFFFF, 32'h7FFF_FFFF, 0);
    send_item(swo_pkg::MODE_LINE, 8'd191, 32'h5A5A_5A5A);
  endtask

  // empty range, unused register slots, range above the wave table size
  task automatic test_range_edges();
    program_regs(10, 9, 4096, 32'h0010_0000, 0);
    send_item(swo_pkg::MODE_LINE, 8'd9, 32'hDEAD_BEEF);
    send_item(swo_pkg::MODE_LINE, 8'd10, 32'hCAFE_F00D);
    wait_idle();
    for (int i = int'(swo_pkg::CFG_PHASE_SPEED) + 1; i < (1 << swo_pkg::CFG_IDX_W); i++)
      cfg_write(swo_pkg::CFG_IDX_W'(i), '1);
    cfg_bus.valid <= 1'b0;
    send_item(swo_pkg::MODE_LINE, 8'd10, 32'h1357_9BDF);
    program_regs(200, 255, 1000, 32'(12345 << 12), 0);
    send_item(swo_pkg::MODE_LINE, 8'd199, 32'h0F0F_0F0F);
    send_item(swo_pkg::MODE_LINE, 8'd200, 32'hF0F0_F0F0);
    send_item(swo_pkg::MODE_LINE, 8'd255, 32'h0000_FFFE);
  endtask

  // phase speed beyond one period in both directions and at the period itself
  task automatic test_phase_wrap();
    program_regs(0, 191, 341, 32'(100 << 12), 32767);
    send_item(swo_pkg::MODE_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_item(swo_pkg::MODE_LINE, 8'd5, 32'h0000_1000);
    program_regs(0, 191, 341, 32'(100 << 12), -32768);
    send_item(swo_pkg::MODE_TICK, 8'd0, 32'h0);
    send_item(swo_pkg::MODE_LINE, 8'd5, 32'h0000_1000);
    program_regs(0, 191, 341, 32'(-(100 << 12)), 19200);
    send_item(swo_pkg::MODE_TICK, 8'd7, 32'h1);
    program_regs(0, 191, 341, 32'(-(100 << 12)), -19200);
    send_item(swo_pkg::MODE_TICK, 8'd7, 32'h1);
    send_item(swo_pkg::MODE_LINE, 8'd191, 32'h0000_1000);
  endtask

  // frames: a tick then a run of consecutive lines around the active range
  task automatic send_frame_chunk();
    int start;
    int run;
    send_item(swo_pkg::MODE_TICK, 8'($urandom), $urandom);
    if ($urandom_range(3) == 0)
      start = $urandom_range(255);
    else
      start = int'(first_q) - 1 + $urandom_range(2);
    if (start < 0)
      start = 0;
    run = $urandom_range(4, 24);
    for (int j = 0; j < run && start + j <= 255; j++)
      send_item(swo_pkg::MODE_LINE, 8'(start + j), $urandom);
  endtask

  task automatic test_random_frames();
    int first;
    int last;
    int step;
    int speed;
    int pick;
    int stop_at;
    logic [31:0] amp;
    while (items_sent < RANDOM_ITEMS + 25) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        first = 0;
        last = 191;
      end else if (pick == 1) begin
        first = $urandom_range(255);
        last = $urandom_range(255);
      end else if (pick == 2) begin
        first = $urandom_range(255);
        last = first;
      end else begin
        first = $urandom_range(191);
        last = $urandom_range(first, 191);
      end
      pick = $urandom_range(7);
      step = (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : $urandom_range(65535);
      pick = $urandom_range(9);
      if (pick == 0)
        amp = 32'h7FFF_FFFF;
      else if (pick == 1)
        amp = 32'h8000_0000;
      else if (pick < 6)
        amp = 32'($urandom_range(262144) - 131072);
      else
        amp = $urandom;
      pick = $urandom_range(7);
      if (pick == 0)
        speed = $urandom_range(65535);
      else if (pick == 1)
        speed = ($urandom_range(1) == 0) ? 19200 : -19200;
      else
        speed = $urandom_range(38400) - 19200;
      program_regs(first, last, step, amp, speed);

      gaps_on = ($urandom_range(3) != 0);
      burst_left = $urandom_range(1, BURST_MAX);
      stop_at = items_sent + $urandom_range(40, 80);
      while (items_sent < stop_at) begin
        if ($urandom_range(4) != 0)
          send_frame_chunk();
        else
          send_item(1'($urandom), 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    real v;
    rst_n = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    line_bus.valid = 1'b0;
    line_bus.mode = swo_pkg::MODE_LINE;
    line_bus.line_index = '0;
    line_bus.line_word = '0;

    // quarter-wave sine in Q12, rounded to nearest
    for (int k = 0; k <= swo_pkg::QUARTER; k++) begin
      v = 4096.0 * $sin(2.0 * 3.14159265358979323846 * real'(k) / 4096.0);
      sine_tab[k] = $rtoi(v + 0.5);
    end

    first_q = '0;
    last_q = swo_pkg::LAST_LINE_RST;
    step_q = '0;
    amp_q = '0;
    speed_q = '0;
    phase_q = 0;
    errors = 0;
    gaps_on = 1'b1;
    burst_left = 4;

    // reset edge lands after time zero so every flop sees it
    #1;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_wave_extremes();
    test_range_edges();
    test_phase_wrap();
    test_random_frames();

    wait_idle();
    $display("covered %0d line beats (%0d inside the wave range) and %0d frame ticks",
             lines_sent, lines_in_range, ticks_sent);
    $display("over %0d register setups with paced input and stalled output",
             setups);
    if (errors == 0)
      $display("tb_scanline_sine_wave_offset: PASS");
    else
      $display("tb_scanline_sine_wave_offset: FAIL");
    $finish;
  end

  // hang guard
  initial begin
    #5ms;
    $display("tb_scanline_sine_wave_offset: FAIL");
    $finish;
  end

endmodule

// ----- scanline_sine_wave_offset.f -----
+incdir+rtl
rtl/swo_pkg.sv
rtl/swo_in_if.sv
rtl/scanline_sine_wave_offset.sv
rtl/swo_checker.sv
tb/sv/tb_scanline_sine_wave_offset.sv
